[hdl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and codes for the ordered list engine: command and result
// items, operation kinds and status codes.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int DefDepth = 16;
  localparam int DataW    = 32;
  localparam int PosW     = 5;
  localparam int CountW   = 5;

  typedef enum logic [2:0] {
    KIND_INS_FRONT = 3'd0,
    KIND_INS_END   = 3'd1,
    KIND_INS_ORDER = 3'd2,
    KIND_DEL_FIRST = 3'd3,
    KIND_DEL_BEFORE = 3'd4,
    KIND_DEL_AFTER = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [DataW-1:0] item_value;
    logic [PosW-1:0]         position;
  } ole_cmd_t;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [DataW-1:0] removed_value;
    logic [CountW-1:0]       entry_count;
  } ole_rsp_t;

endpackage

[hdl/ordered_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine_unit
// Bounded ordered store of signed 32-bit values with front, end and sorted
// inserts and position-based deletes, run by a small sequencer over one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A command item is taken when start is high and busy is low. busy stays
//   high until the result has been shown. The result item appears on rsp for
//   exactly one cycle with done high; the receiver cannot stall it.
//   Each element moved takes one RAM read and one RAM write through the
//   single port pair. Refused or invalid commands go straight to done;
//   insert at end, or into an empty store, writes the value at once;
//   insert at front shifts every element up one place first; insert
//   ascending scans from index 0 for the first element not less than the
//   value, shifts it and those above it up and writes the value there, or
//   writes at the end if there is none; delete at index i reads the element,
//   then shifts those above it down one place. The sorted scan runs one
//   signed compare per element read, so the shift and the scan together set
//   the latency; a new item is taken the cycle after done, not before.
//   Reset clears the element count and the sequencer; RAM contents are left
//   as they are, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit #(
  parameter int DEPTH = ole_pkg::DefDepth
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ole_pkg::ole_cmd_t cmd,
  output logic              busy,
  output logic              done,
  output ole_pkg::ole_rsp_t rsp
);
  import ole_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > PosW + 1) ? CW : PosW + 1;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_SCAN_RD  = 11'b00000000010,
    S_SCAN_CMP = 11'b00000000100,
    S_UP_RD    = 11'b00000001000,
    S_UP_WR    = 11'b00000010000,
    S_INS_WR   = 11'b00000100000,
    S_DEL_RD   = 11'b00001000000,
    S_DEL_CAP  = 11'b00010000000,
    S_DN_RD    = 11'b00100000000,
    S_DN_WR    = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t                  state;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           ptr;
  logic [CW-1:0]           tgt;
  logic signed [DataW-1:0] val;
  logic [1:0]              status;
  logic [DataW-1:0]        removed;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DataW-1:0]        ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DataW-1:0]        ram_rdata;

  logic [CW-1:0]           ptr_dec;
  logic [CW-1:0]           ptr_inc;
  logic [PW-1:0]           pos_x;
  logic [PW-1:0]           cnt_x;
  logic                    ge;

  assign ptr_dec = ptr - CW'(1);
  assign ptr_inc = ptr + CW'(1);
  assign pos_x   = PW'(cmd.position);
  assign cnt_x   = PW'(cnt);
  // compare used by the sorted scan: stored element not less than the new value
  assign ge      = $signed(ram_rdata) >= val;

  ole_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(ptr);
    ram_wdata = ram_rdata;
    ram_raddr = AW'(ptr);
    unique case (state)
      S_UP_RD: ram_raddr = AW'(ptr_dec);
      S_DEL_RD: ram_raddr = AW'(tgt);
      S_UP_WR: ram_we = 1'b1;
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(tgt);
        ram_wdata = val;
      end
      S_DN_WR: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(ptr_dec);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            val     <= cmd.item_value;
            status  <= ST_OK;
            removed <= '0;
            state   <= S_DONE;
            unique case (cmd.kind) inside
              KIND_INS_FRONT, KIND_INS_END, KIND_INS_ORDER: begin
                if (cnt >= CW'(DEPTH)) begin
                  status <= ST_FULL;
                end else if (cmd.kind == KIND_INS_END || cnt == '0) begin
                  tgt   <= (cmd.kind == KIND_INS_END) ? cnt : '0;
                  state <= S_INS_WR;
                end else if (cmd.kind == KIND_INS_FRONT) begin
                  tgt   <= '0;
                  ptr   <= cnt;
                  state <= S_UP_RD;
                end else begin
                  ptr   <= '0;
                  state <= S_SCAN_RD;
                end
              end
              KIND_DEL_FIRST, KIND_DEL_BEFORE, KIND_DEL_AFTER: begin
                if (cnt == '0) begin
                  status <= ST_EMPTY;
                end else if (cmd.kind == KIND_DEL_FIRST) begin
                  tgt   <= '0;
                  state <= S_DEL_RD;
                end else if (cmd.kind == KIND_DEL_BEFORE) begin
                  if (pos_x < PW'(2) || pos_x - PW'(1) > cnt_x) begin
                    status <= ST_BADPOS;
                  end else begin
                    tgt   <= CW'(pos_x - PW'(2));
                    state <= S_DEL_RD;
                  end
                end else begin
                  if (pos_x < PW'(1) || pos_x + PW'(1) > cnt_x) begin
                    status <= ST_BADPOS;
                  end else begin
                    tgt   <= CW'(pos_x);
                    state <= S_DEL_RD;
                  end
                end
              end
              default: status <= ST_BADPOS;
            endcase
          end
        end
        S_SCAN_RD: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (ge) begin
            tgt   <= ptr;
            ptr   <= cnt;
            state <= S_UP_RD;
          end else if (ptr_inc == cnt) begin
            tgt   <= cnt;
            state <= S_INS_WR;
          end else begin
            ptr   <= ptr_inc;
            state <= S_SCAN_RD;
          end
        end
        S_UP_RD: state <= S_UP_WR;
        S_UP_WR: begin
          ptr   <= ptr_dec;
          state <= (ptr_dec == tgt) ? S_INS_WR : S_UP_RD;
        end
        S_INS_WR: begin
          cnt   <= cnt + CW'(1);
          state <= S_DONE;
        end
        S_DEL_RD: state <= S_DEL_CAP;
        S_DEL_CAP: begin
          removed <= ram_rdata;
          if (tgt + CW'(1) == cnt) begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end else begin
            ptr   <= tgt + CW'(1);
            state <= S_DN_RD;
          end
        end
        S_DN_RD: state <= S_DN_WR;
        S_DN_WR: begin
          ptr <= ptr_inc;
          if (ptr_inc == cnt) begin
            cnt   <= cnt - CW'(1);
            state <= S_DONE;
          end else begin
            state <= S_DN_RD;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy              = (state != S_IDLE);
  assign done              = (state == S_DONE);
  assign rsp.status        = status;
  assign rsp.removed_value = removed;
  assign rsp.entry_count   = CountW'(cnt);

endmodule

[hdl/ole_ram.sv]
// ----------------------------------------------------------------------------
// ole_ram
// Element storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ole_ram #(
  parameter int DEPTH = ole_pkg::DefDepth,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [ole_pkg::DataW-1:0]  wdata,
  input  logic [AW-1:0]              raddr,
  output logic [ole_pkg::DataW-1:0]  rdata
);
  import ole_pkg::*;

  logic [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
